// ===== hw/rtl/aard_pkg.sv =====
package aard_pkg;

	localparam int SAMPLE_BITS_DEF    = 10;
	localparam int DISPLAY_DIGITS_DEF = 6;

	localparam int LEN_W      = 7;
	localparam int MV_W       = 13;
	localparam int SLOPE_W    = 16;
	localparam int OFFSET_W   = 20;
	localparam int RES_W      = 20;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam int QUEUE_DEPTH     = 2;
	localparam int LINEAR_DIVISOR  = 100;
	localparam int BLANKED_DIGITS  = 3;

	localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'd10;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_MV = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 3'd3;

	localparam logic [LEN_W-1:0]    BLOCK_LENGTH_RESET = 7'd20;
	localparam logic [MV_W-1:0]     REFERENCE_MV_RESET = 13'd2500;
	localparam logic [SLOPE_W-1:0]  SLOPE_RESET        = 16'd3997;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET       = 20'd78910;

	typedef struct packed {
		logic [LEN_W-1:0]    block_length;
		logic [MV_W-1:0]     reference_millivolts;
		logic [SLOPE_W-1:0]  slope_coefficient;
		logic [OFFSET_W-1:0] offset_coefficient;
	} cfg_t;

	typedef struct packed {
		logic [RES_W-1:0]                      resistance_hundredths;
		logic [MV_W-1:0]                       input_millivolts;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0]    digits;
	} result_t;

	// Ten to the power n, used for elaboration-time constants only.
	function automatic int pow10(input int n);
		int p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

endpackage

// ===== hw/rtl/aard_queue.sv =====
module aard_queue
	import aard_pkg::*;
#(
	parameter int WIDTH = 24,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             is_full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             is_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign is_empty = (cnt_q == '0);
	assign do_wr    = wr_en && !is_full;
	assign do_rd    = rd_en && !is_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/aard_front.sv =====
module aard_front
	import aard_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [LEN_W-1:0]             block_length,
	input  logic                         push,
	input  logic [SAMPLE_BITS-1:0]       adc_sample,
	output logic                         full,
	output logic                         q_push,
	output logic [SAMPLE_BITS+LEN_W-1:0] q_sum,
	output logic [LEN_W-1:0]             q_count,
	input  logic                         q_full
);

	localparam int SUM_W = SAMPLE_BITS + LEN_W;

	logic [SUM_W-1:0] sum_q;
	logic [LEN_W-1:0] taken_q;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] count;
	logic [SUM_W-1:0] sum_next;
	logic             ending;
	logic             accept;

	// A zero block length behaves as one sample per block.
	assign len      = (block_length == '0) ? LEN_W'(1) : block_length;
	assign count    = taken_q + 1'b1;
	assign ending   = (count >= len);
	assign full     = ending && q_full;
	assign accept   = push && !full;
	assign sum_next = sum_q + SUM_W'(adc_sample);

	assign q_push  = accept && ending;
	assign q_sum   = sum_next;
	assign q_count = count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (accept) begin
			if (ending) begin
				sum_q   <= '0;
				taken_q <= '0;
			end else begin
				sum_q   <= sum_next;
				taken_q <= count;
			end
		end
	end

endmodule

// ===== hw/rtl/aard_divider.sv =====
module aard_divider
	import aard_pkg::*;
#(
	parameter int DW = 30,
	parameter int VW = SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	// Restoring division, one quotient bit per cycle, MSB first.
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/aard_back.sv =====
module aard_back
	import aard_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int DISPLAY_DIGITS = DISPLAY_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         q_empty,
	input  logic [SAMPLE_BITS+LEN_W-1:0] q_sum,
	input  logic [LEN_W-1:0]             q_count,
	output logic                         q_pop,
	input  logic                         out_pop,
	output logic                         out_empty,
	output result_t                      result
);

	localparam int SUM_W       = SAMPLE_BITS + LEN_W;
	localparam int PROD_W      = SAMPLE_BITS + MV_W;
	localparam int MUL_W       = SLOPE_W + MV_W;
	localparam int LIN_W       = MUL_W + 1;
	localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
	localparam int LIMIT       = pow10(DISPLAY_DIGITS) - 1;
	localparam int SAT_W       = $clog2(LIMIT + 1);
	localparam int BCD_W       = DISPLAY_DIGITS * DIGIT_W;
	localparam int BCNT_W      = $clog2(SAT_W + 1);
	localparam int MV_SHIFT    = PROD_W + SAMPLE_BITS;
	localparam int MV_RECIP_W  = PROD_W + 1;
	localparam int RES_SHIFT   = LIN_W + $clog2(LINEAR_DIVISOR);
	localparam int RES_RECIP_W = LIN_W + 1;
	localparam int QUO_W       = 2 * LIN_W + 1 - RES_SHIFT;

	// Rounded-up reciprocals. With the shift set to the dividend width plus the
	// divisor's bit length, the truncated product equals the truncated quotient.
	localparam logic [MV_RECIP_W-1:0] MV_RECIP = MV_RECIP_W'(
		((64'd1 << MV_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));
	localparam logic [RES_RECIP_W-1:0] RES_RECIP = RES_RECIP_W'(
		((64'd1 << RES_SHIFT) + 64'(LINEAR_DIVISOR) - 64'd1) / 64'(LINEAR_DIVISOR));

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_AVG     = 4'd1;
	localparam logic [3:0] ST_MUL_MV  = 4'd2;
	localparam logic [3:0] ST_DIV_MV  = 4'd3;
	localparam logic [3:0] ST_MUL_RES = 4'd5;
	localparam logic [3:0] ST_DIV_RES = 4'd6;
	localparam logic [3:0] ST_RES     = 4'd7;
	localparam logic [3:0] ST_BCD     = 4'd8;
	localparam logic [3:0] ST_FIN     = 4'd9;

	logic [3:0]             state_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [PROD_W-1:0]      prod_q;
	logic [MV_W-1:0]        mv_q;
	logic [LIN_W-1:0]       lin_q;
	logic [QUO_W-1:0]       res_quo_q;
	logic [SAT_W-1:0]       sat_q;
	logic [SAT_W-1:0]       bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCNT_W-1:0]      bcnt_q;
	result_t                out_q;
	logic                   out_valid_q;

	logic                   div_start;
	logic                   div_done;
	logic [SUM_W-1:0]       div_quo;

	logic [PROD_W-1:0]      mv_prod;
	logic [MUL_W-1:0]       res_prod;
	logic [2*PROD_W:0]      mv_wide;
	logic [2*LIN_W:0]       res_wide;
	logic [SAT_W-1:0]       sat_val;
	logic [BCD_W-1:0]       bcd_adj;
	logic [BCD_W-1:0]       bcd_next;
	logic                   out_load;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_val;
	result_t                result_next;

	// The average divides by the sample count, which varies from block to block.
	aard_divider #(
		.DW(SUM_W),
		.VW(LEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(q_sum),
		.divisor (q_count),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign div_start = (state_q == ST_IDLE) && !q_empty;

	assign mv_prod  = avg_q * cfg.reference_millivolts;
	assign res_prod = cfg.slope_coefficient * mv_q;
	assign mv_wide  = prod_q * MV_RECIP;
	assign res_wide = lin_q * RES_RECIP;
	assign sat_val  = (64'(res_quo_q) > 64'(LIMIT)) ? SAT_W'(LIMIT) : SAT_W'(res_quo_q);

	// Double dabble: add three to every digit of five or more, then shift.
	always_comb begin
		for (int i = 0; i < DISPLAY_DIGITS; i++) begin
			bcd_adj[i*DIGIT_W +: DIGIT_W] = (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) ?
				bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3 : bcd_q[i*DIGIT_W +: DIGIT_W];
		end
	end

	assign bcd_next = {bcd_adj[BCD_W-2:0], bin_q[SAT_W-1]};

	for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
		localparam int POS = NUM_DIGITS - 1 - k;
		localparam logic [31:0] WEIGHT = 32'(pow10(POS));
		logic [DIGIT_W-1:0] raw;
		if (POS < DISPLAY_DIGITS) begin : g_show
			assign raw = bcd_q[POS*DIGIT_W +: DIGIT_W];
		end else begin : g_zero
			assign raw = '0;
		end
		assign digit_val[k] = ((k < BLANKED_DIGITS) && (32'(sat_q) < WEIGHT)) ?
			BLANK_CODE : raw;
	end

	always_comb begin
		result_next.resistance_hundredths = RES_W'(sat_q);
		result_next.input_millivolts      = mv_q;
		result_next.digits                = digit_val;
	end

	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_pop);
	assign out_empty = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_AVG: begin
				if (div_done) begin
					avg_q <= div_quo[SAMPLE_BITS-1:0];
				end
			end
			ST_MUL_MV: begin
				prod_q <= mv_prod;
			end
			ST_DIV_MV: begin
				mv_q <= mv_wide[MV_SHIFT +: MV_W];
			end
			ST_MUL_RES: begin
				lin_q <= LIN_W'(res_prod) + LIN_W'(cfg.offset_coefficient);
			end
			ST_DIV_RES: begin
				res_quo_q <= res_wide[2*LIN_W:RES_SHIFT];
			end
			ST_RES: begin
				sat_q  <= sat_val;
				bin_q  <= sat_val;
				bcd_q  <= '0;
				bcnt_q <= BCNT_W'(SAT_W);
			end
			ST_BCD: begin
				bcd_q  <= bcd_next;
				bin_q  <= {bin_q[SAT_W-2:0], 1'b0};
				bcnt_q <= bcnt_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= result_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (div_done) begin
						state_q <= ST_MUL_MV;
					end
				end
				ST_MUL_MV: begin
					state_q <= ST_DIV_MV;
				end
				ST_DIV_MV: begin
					state_q <= ST_MUL_RES;
				end
				ST_MUL_RES: begin
					state_q <= ST_DIV_RES;
				end
				ST_DIV_RES: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					state_q <= ST_BCD;
				end
				ST_BCD: begin
					if (bcnt_q == BCNT_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/averaged_adc_resistance_display.sv =====
// Block-averaging resistance meter. ADC samples are pushed one beat at a time and summed in
// blocks of block_length samples (a length of zero counts as one); the last sample of a block
// hands the sum and count to a two-entry queue, and the block keeps taking samples at one per
// cycle while the arithmetic side works, unless a block ends while the queue is full. For each
// block the arithmetic side computes the truncated average, millivolts as
// avg * reference_millivolts / (2^SAMPLE_BITS - 1), and resistance in hundredths of an ohm as
// (slope * mv + offset) / 100, saturated at 10^DISPLAY_DIGITS - 1, then converts it to decimal
// for six display digits with the top three blanked (code 10) when the value is below their
// weight. The average comes from a divider producing one quotient bit per cycle over the
// SUM_W = SAMPLE_BITS + 7 bit sum; the two divisions by constants are reciprocal
// multiplications; a one-bit-per-cycle binary to decimal conversion follows. The arithmetic
// side takes one block at a time and pops the next only after the last result has been
// loaded into the result register. Configuration writes are always ready and are meant to be
// issued only while no block result is pending.
module averaged_adc_resistance_display
	import aard_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int DISPLAY_DIGITS = DISPLAY_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	output logic                   full,
	output logic                   empty,
	input  logic                   pop,
	output logic [RES_W-1:0]       resistance_hundredths,
	output logic [MV_W-1:0]        input_millivolts,
	output logic [DIGIT_W-1:0]     digit_one,
	output logic [DIGIT_W-1:0]     digit_two,
	output logic [DIGIT_W-1:0]     digit_three,
	output logic [DIGIT_W-1:0]     digit_four,
	output logic [DIGIT_W-1:0]     digit_five,
	output logic [DIGIT_W-1:0]     digit_six,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int SUM_W = SAMPLE_BITS + LEN_W;
	localparam int ITEM_W = SUM_W + LEN_W;

	cfg_t              cfg_q;
	logic              q_push;
	logic [SUM_W-1:0]  q_sum_in;
	logic [LEN_W-1:0]  q_count_in;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	logic [ITEM_W-1:0] q_rd_data;
	result_t           result;

	// The configuration port never stalls. Unknown register indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_length         <= BLOCK_LENGTH_RESET;
			cfg_q.reference_millivolts <= REFERENCE_MV_RESET;
			cfg_q.slope_coefficient    <= SLOPE_RESET;
			cfg_q.offset_coefficient   <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLOCK_LENGTH: cfg_q.block_length         <= cfg_data[LEN_W-1:0];
				REG_REFERENCE_MV: cfg_q.reference_millivolts <= cfg_data[MV_W-1:0];
				REG_SLOPE:        cfg_q.slope_coefficient    <= cfg_data[SLOPE_W-1:0];
				REG_OFFSET:       cfg_q.offset_coefficient   <= cfg_data[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: accumulates samples and closes blocks. It only stalls when a block
	// ends while the queue is already full.
	aard_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.block_length(cfg_q.block_length),
		.push        (push),
		.adc_sample  (adc_sample),
		.full        (full),
		.q_push      (q_push),
		.q_sum       (q_sum_in),
		.q_count     (q_count_in),
		.q_full      (q_full)
	);

	// Completed blocks wait here as a sum and its sample count.
	aard_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data ({q_sum_in, q_count_in}),
		.is_full (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.is_empty(q_empty)
	);

	// Back: division, scaling, saturation and digit conversion, with a result
	// register that holds the oldest result until it is popped.
	aard_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.DISPLAY_DIGITS(DISPLAY_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_sum    (q_rd_data[ITEM_W-1:LEN_W]),
		.q_count  (q_rd_data[LEN_W-1:0]),
		.q_pop    (q_pop),
		.out_pop  (pop),
		.out_empty(empty),
		.result   (result)
	);

	assign resistance_hundredths = result.resistance_hundredths;
	assign input_millivolts      = result.input_millivolts;
	assign digit_one             = result.digits[0];
	assign digit_two             = result.digits[1];
	assign digit_three           = result.digits[2];
	assign digit_four            = result.digits[3];
	assign digit_five            = result.digits[4];
	assign digit_six             = result.digits[5];

endmodule
